FILE: hdl/sida_pkg.sv
`timescale 1ns / 1ps

package sida_pkg;

  // Width of the integer; bit VALUE_BITS-1 is the sign.
  localparam int VALUE_BITS = 64;

  // Decimal digits that cover 2**(VALUE_BITS-1).
  localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_BITS = 4 * DIGITS;
  localparam int IDX_BITS = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  // Shift-and-add-3 steps done in each pipeline stage.
  localparam int STEP_BITS = 8;
  localparam int STAGES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS = STAGES * STEP_BITS;

  // Field widths of the ports.
  localparam int NUMBER_BITS = 64;
  localparam int ROOM_BITS = 16;
  localparam int CHAR_BITS = 8;
  localparam int LEN_BITS = 5;

  localparam logic [ROOM_BITS-1:0] ROOM_NEEDED = 16'd21;
  localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 8'h30;
  localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 8'h2D;

  // Item state carried down the conversion pipeline.
  typedef struct packed {
    logic neg;
    logic err;
    logic [PAD_BITS-1:0] bin;
    logic [BCD_BITS-1:0] bcd;
  } work_t;

endpackage

FILE: hdl/sida_dabble_stage.sv
`timescale 1ns / 1ps

module sida_dabble_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 enable,
  input  logic                 valid_in,
  input  sida_pkg::work_t      work_in,
  output logic                 valid_out,
  output sida_pkg::work_t      work_out
);

  sida_pkg::work_t work_next;

  // Run the shift-and-add-3 steps for this stage's slice of bits
  always_comb begin
    logic [sida_pkg::BCD_BITS-1:0] bcd;
    logic [sida_pkg::PAD_BITS-1:0] bin;
    bcd = work_in.bcd;
    bin = work_in.bin;
    for (int k = 0; k < sida_pkg::STEP_BITS; k++) begin
      for (int d = 0; d < sida_pkg::DIGITS; d++) begin
        if (bcd[d*4 +: 4] >= 4'd5) begin
          bcd[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
        end
      end
      bcd = {bcd[sida_pkg::BCD_BITS-2:0], bin[sida_pkg::PAD_BITS-1]};
      bin = {bin[sida_pkg::PAD_BITS-2:0], 1'b0};
    end
    work_next.neg = work_in.neg;
    work_next.err = work_in.err;
    work_next.bin = bin;
    work_next.bcd = bcd;
  end

  // Advance when downstream has room, otherwise hold
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (enable) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      work_out <= work_next;
    end
  end

endmodule

FILE: hdl/sida_emitter.sv
`timescale 1ns / 1ps

module sida_emitter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             valid_in,
  input  sida_pkg::work_t                  work_in,
  output logic                             free,
  output logic                             strobe,
  output logic [sida_pkg::CHAR_BITS-1:0]   char_code,
  output logic                             last,
  output logic [sida_pkg::LEN_BITS-1:0]    text_length,
  output logic                             error
);

  logic                            active;
  logic                            err;
  logic                            sign;
  logic [sida_pkg::IDX_BITS-1:0]   idx;
  logic [sida_pkg::LEN_BITS-1:0]   len;
  logic [sida_pkg::BCD_BITS-1:0]   bcd;

  logic                            emit_last;
  logic                            load;
  logic [sida_pkg::IDX_BITS-1:0]   top;
  logic [3:0]                      digit;

  // Find the most significant nonzero digit; zero keeps digit 0
  always_comb begin
    top = '0;
    for (int d = 0; d < sida_pkg::DIGITS; d++) begin
      if (work_in.bcd[d*4 +: 4] != 4'd0) begin
        top = sida_pkg::IDX_BITS'(d);
      end
    end
  end

  assign digit     = bcd[idx*4 +: 4];
  assign emit_last = active && (err || (!sign && idx == '0));
  assign free      = !active || emit_last;
  assign load      = valid_in && free;

  // Load a converted item or step through its characters
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= 1'b1;
    end else if (emit_last) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      err  <= work_in.err;
      sign <= work_in.neg && !work_in.err;
      idx  <= top;
      len  <= sida_pkg::LEN_BITS'(top) + sida_pkg::LEN_BITS'(1)
              + sida_pkg::LEN_BITS'(work_in.neg);
      bcd  <= work_in.bcd;
    end else if (active) begin
      if (sign) begin
        sign <= 1'b0;
      end else if (idx != '0) begin
        idx <= idx - 1'b1;
      end
    end
  end

  // Register one character per cycle on the result ports
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      if (err) begin
        char_code   <= '0;
        last        <= 1'b1;
        text_length <= '0;
        error       <= 1'b1;
      end else if (sign) begin
        char_code   <= sida_pkg::ASCII_MINUS;
        last        <= 1'b0;
        text_length <= '0;
        error       <= 1'b0;
      end else begin
        char_code   <= sida_pkg::ASCII_ZERO + {4'd0, digit};
        last        <= (idx == '0);
        text_length <= (idx == '0) ? len : '0;
        error       <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/signed_int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
// Path: the first character of an item passes the capture register,
// 8 shift-and-add-3 stages, the emitter load and the output register.
// Throughput: one character per cycle; an item holds the emitter until
// its last character is sent (1 to 20 characters, one for an error item).
// rst clears the pipeline valid bits and the emitter; the receiver cannot stall.

module signed_int_to_decimal_ascii_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [sida_pkg::NUMBER_BITS-1:0]   number,
  input  logic [sida_pkg::ROOM_BITS-1:0]     room,
  output logic                               strobe,
  output logic [sida_pkg::CHAR_BITS-1:0]     char_code,
  output logic                               last,
  output logic [sida_pkg::LEN_BITS-1:0]      text_length,
  output logic                               error
);

  localparam int S = sida_pkg::STAGES;

  logic                   valid [0:S];
  sida_pkg::work_t        work  [0:S];
  logic                   enable [0:S];
  logic                   free;
  logic                   accept;

  logic [sida_pkg::VALUE_BITS-1:0] value;
  logic [sida_pkg::VALUE_BITS-1:0] mag;
  logic                            neg;

  // Stall chain: a stage takes new data when empty or when it moves on
  always_comb begin
    enable[S] = !valid[S] || free;
    for (int r = S - 1; r >= 0; r--) begin
      enable[r] = !valid[r] || enable[r+1];
    end
  end

  assign busy   = !enable[0];
  assign accept = start && !busy;

  // Capture: form the magnitude and check the room
  assign value = number[sida_pkg::VALUE_BITS-1:0];
  assign neg   = value[sida_pkg::VALUE_BITS-1];
  assign mag   = neg ? (~value + 1'b1) : value;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (enable[0]) begin
      valid[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (enable[0]) begin
      work[0].neg <= neg;
      work[0].err <= (room < sida_pkg::ROOM_NEEDED);
      work[0].bin <= sida_pkg::PAD_BITS'(mag);
      work[0].bcd <= '0;
    end
  end

  // Binary to BCD pipeline
  for (genvar s = 0; s < S; s++) begin : g_stage
    sida_dabble_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .enable    (enable[s+1]),
      .valid_in  (valid[s]),
      .work_in   (work[s]),
      .valid_out (valid[s+1]),
      .work_out  (work[s+1])
    );
  end

  // Serialize characters onto the result ports
  sida_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .valid_in    (valid[S]),
    .work_in     (work[S]),
    .free        (free),
    .strobe      (strobe),
    .char_code   (char_code),
    .last        (last),
    .text_length (text_length),
    .error       (error)
  );

  // Checks
  a_error_form: assert property (@(posedge clk) disable iff (rst)
    strobe && error |-> last && char_code == '0 && text_length == '0)
    else $error("error result malformed");

  a_mid_char: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> !error && text_length == '0)
    else $error("length or error on a middle character");

  a_last_len: assert property (@(posedge clk) disable iff (rst)
    strobe && last && !error |-> text_length != '0 && text_length <= 5'd20)
    else $error("bad text length on last character");

  a_minus_first: assert property (@(posedge clk) disable iff (rst)
    strobe && char_code == sida_pkg::ASCII_MINUS |-> !last ##1 strobe)
    else $error("minus sign not followed by a digit");

endmodule

FILE: sim/signed_int_to_decimal_ascii_unit_tb.sv
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_unit_tb;

  localparam int RANDOM_ITEMS = 140;
  localparam int QUIET_TAIL = 30;
  localparam int DIRECTED_ROWS = 20;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - sida_pkg::VALUE_BITS);
  localparam logic [63:0] MOST_NEGATIVE = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POSITIVE = 64'h7FFF_FFFF_FFFF_FFFF;

  // One character of decimal text as it leaves the block
  typedef struct packed {
    logic [sida_pkg::CHAR_BITS-1:0] char_code;
    logic                           last;
    logic [sida_pkg::LEN_BITS-1:0]  text_length;
    logic                           error;
  } char_rec_t;

  // Directed row: text is right-justified, len 0 marks the error result
  typedef struct {
    logic [sida_pkg::NUMBER_BITS-1:0] num;
    logic [sida_pkg::ROOM_BITS-1:0]   rm;
    bit                               typed;
    logic [8*20-1:0]                  text;
    int                               len;
  } stim_row_t;

  logic                             clk;
  logic                             rst;
  logic                             start;
  logic                             busy;
  logic [sida_pkg::NUMBER_BITS-1:0] number;
  logic [sida_pkg::ROOM_BITS-1:0]   room;
  logic                             strobe;
  logic [sida_pkg::CHAR_BITS-1:0]   char_code;
  logic                             last;
  logic [sida_pkg::LEN_BITS-1:0]    text_length;
  logic                             error;

  char_rec_t pending_chars[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  stim_row_t directed_rows [DIRECTED_ROWS];

  signed_int_to_decimal_ascii_unit DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .number(number),
    .room(room),
    .strobe(strobe),
    .char_code(char_code),
    .last(last),
    .text_length(text_length),
    .error(error)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Predict the characters of one item and queue them
  task automatic queue_decimal_text(input logic [63:0] num, input logic [15:0] rm);
    logic [63:0] v;
    logic [63:0] mag;
    logic        negative;
    logic [7:0]  digs [20];
    int          nd;
    int          n;
    char_rec_t   r;
    v = num & VALUE_MASK;
    negative = v[sida_pkg::VALUE_BITS-1];
    if (rm < sida_pkg::ROOM_NEEDED) begin
      r = '{8'h00, 1'b1, 5'd0, 1'b1};
      pending_chars.push_back(r);
      return;
    end
    mag = negative ? ((~v + 64'd1) & VALUE_MASK) : v;
    nd = 0;
    do begin
      digs[nd] = sida_pkg::ASCII_ZERO + 8'(mag % 64'd10);
      nd++;
      mag = mag / 64'd10;
    end while (mag != 64'd0 && nd < 20);
    n = nd + (negative ? 1 : 0);
    if (negative) begin
      r = '{sida_pkg::ASCII_MINUS, 1'b0, 5'd0, 1'b0};
      pending_chars.push_back(r);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      r = '{digs[k], k == 0, (k == 0) ? 5'(n) : 5'd0, 1'b0};
      pending_chars.push_back(r);
    end
  endtask

  // Offer one item, hold it until taken, then queue what it should produce
  task automatic send_item(input logic [63:0] num, input logic [15:0] rm,
                           input bit typed, input logic [8*20-1:0] text,
                           input int len);
    char_rec_t r;
    start <= 1'b1;
    number <= num;
    room <= rm;
    do @(posedge clk); while (busy);
    if (!typed) begin
      queue_decimal_text(num, rm);
    end else if (len == 0) begin
      r = '{8'h00, 1'b1, 5'd0, 1'b1};
      pending_chars.push_back(r);
    end else begin
      for (int k = 0; k < len; k++) begin
        r = '{text[8*(len-1-k) +: 8], k == len - 1, (k == len - 1) ? 5'(len) : 5'd0, 1'b0};
        pending_chars.push_back(r);
      end
    end
  endtask

  // Drop start for a burst of idle cycles
  task automatic idle_for(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off until every queued character has come out
  task automatic wait_for_drain();
    start <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // Pick a number from a mix of shapes that stress the digit count
  function automatic logic [63:0] pick_number();
    logic [63:0] v;
    logic [63:0] p;
    int          k;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = v >> $urandom_range(0, 63);
      1: begin
        p = 64'd1;
        k = $urandom_range(0, 18);
        repeat (k) p = p * 64'd10;
        v = p + 64'($urandom_range(0, 2)) - 64'd1;
      end
      2: begin
        case ($urandom_range(0, 5))
          0: v = MOST_NEGATIVE;
          1: v = MOST_POSITIVE;
          2: v = 64'd0;
          3: v = {64{1'b1}};
          4: v = MOST_NEGATIVE + 64'd1;
          default: v = MOST_POSITIVE - 64'd1;
        endcase
        return v;
      end
      3: v = 64'($urandom_range(0, 1000));
      default: ;
    endcase
    if ($urandom_range(0, 1)) v = ~v + 64'd1;
    return v;
  endfunction

  function automatic logic [15:0] pick_room();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 20));
      1: return 16'hFFFF;
      2: return sida_pkg::ROOM_NEEDED;
      default: return 16'($urandom_range(21, 65535));
    endcase
  endfunction

  // Compare each strobed character with the oldest prediction
  always @(posedge clk) begin
    char_rec_t want;
    if (!rst && strobe) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character: char_code %0h last %0b error %0b",
               char_code, last, error);
        mismatch_count++;
      end else begin
        want = pending_chars.pop_front();
        if (char_code !== want.char_code) begin
          $error("char_code: expected %0h, got %0h", want.char_code, char_code);
          mismatch_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          mismatch_count++;
        end
        if (text_length !== want.text_length) begin
          $error("text_length: expected %0d, got %0d", want.text_length, text_length);
          mismatch_count++;
        end
        if (error !== want.error) begin
          $error("error: expected %0b, got %0b", want.error, error);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    number = '0;
    room = '0;

    directed_rows = '{
      '{64'd0, 16'd21, 1'b1, "0", 1},
      '{64'd1, 16'hFFFF, 1'b1, "1", 1},
      '{64'hFFFF_FFFF_FFFF_FFFF, 16'd21, 1'b1, "-1", 2},
      '{MOST_POSITIVE, 16'd100, 1'b1, "9223372036854775807", 19},
      '{MOST_NEGATIVE, 16'd21, 1'b1, "-9223372036854775808", 20},
      '{64'd12345, 16'd20, 1'b1, "", 0},
      '{64'hFFFF_FFFF_FFFF_FFFB, 16'd0, 1'b1, "", 0},
      '{64'd0, 16'd0, 1'b1, "", 0},
      '{MOST_POSITIVE, 16'd20, 1'b1, "", 0},
      '{MOST_NEGATIVE, 16'd20, 1'b1, "", 0},
      '{64'd9, 16'd30, 1'b0, "", 0},
      '{64'd10, 16'd22, 1'b0, "", 0},
      '{64'hFFFF_FFFF_FFFF_FFF6, 16'd21, 1'b0, "", 0},
      '{64'hFFFF_FFFF_FFFF_FFFE, 16'd4000, 1'b0, "", 0},
      '{64'd999999999999999999, 16'd21, 1'b0, "", 0},
      '{64'd1000000000000000000, 16'd21, 1'b0, "", 0},
      '{64'hAAAA_AAAA_AAAA_AAAA, 16'hFFFF, 1'b0, "", 0},
      '{64'h5555_5555_5555_5555, 16'h8000, 1'b0, "", 0},
      '{64'hDEAD_BEEF_0123_4567, 16'h7FFF, 1'b0, "", 0},
      '{MOST_NEGATIVE + 64'd1, 16'd21, 1'b0, "", 0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_item(directed_rows[i].num, directed_rows[i].rm, directed_rows[i].typed,
                directed_rows[i].text, directed_rows[i].len);
      if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 6));
    end
    wait_for_drain();

    // Random items; quiet tail keeps the pipe full at the end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_item(pick_number(), pick_room(), 1'b0, '0, 0);
      if (i == RANDOM_ITEMS / 2) wait_for_drain();
      else if (i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        idle_for($urandom_range(1, 6));
    end
    start <= 1'b0;

    // Drain, then allow for stray characters
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
